>>> sv/assert_macros.svh
// Assertion macros shared by the frame builder RTL.
// Included by the modules that check their own control logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define MBRFB_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("frame builder assertion failed");

// Check that a consequent holds in the cycle after an antecedent.
`define MBRFB_ASSERT_NEXT(label, clk, rst, ante, cons) \
  `MBRFB_ASSERT(label, clk, rst, (ante) |=> (cons))

`endif

>>> sv/mbrfb_pkg.sv
// Types, constants and helper functions of the Modbus request frame builder.
// No dependencies; imported by every module of the block.
package mbrfb_pkg;

  localparam logic [15:0] CRC_INIT    = 16'hFFFF;
  localparam logic [15:0] CRC_POLY    = 16'hA001;
  localparam logic [7:0]  SLAVE_RESET = 8'h93;
  localparam logic [7:0]  FUNC_RESET  = 8'h03;
  localparam int          CRC_BYTES   = 6;

  // Byte positions within a frame
  localparam logic [2:0] POS_ADDR     = 3'd0;
  localparam logic [2:0] POS_FUNC     = 3'd1;
  localparam logic [2:0] POS_START_HI = 3'd2;
  localparam logic [2:0] POS_START_LO = 3'd3;
  localparam logic [2:0] POS_COUNT_HI = 3'd4;
  localparam logic [2:0] POS_COUNT_LO = 3'd5;
  localparam logic [2:0] POS_CRC_LO   = 3'd6;
  localparam logic [2:0] POS_CRC_HI   = 3'd7;

  // Configuration register indexes
  localparam logic CFG_SLAVE_ADDRESS = 1'b0;
  localparam logic CFG_FUNCTION_CODE = 1'b1;

  typedef struct packed {
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_register;
    logic [15:0] register_count;
  } frame_t;

  typedef struct packed {
    frame_t      frame;
    logic [15:0] crc;
  } stage_t;

  // One byte of the Modbus CRC-16, bit by bit
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Byte of a frame at a given transmit position
  function automatic logic [7:0] frame_byte_at(input frame_t f, input logic [15:0] crc,
                                               input logic [2:0] pos);
    logic [7:0] b;
    case (pos)
      POS_ADDR:     b = f.slave_address;
      POS_FUNC:     b = f.function_code;
      POS_START_HI: b = f.start_register[15:8];
      POS_START_LO: b = f.start_register[7:0];
      POS_COUNT_HI: b = f.register_count[15:8];
      POS_COUNT_LO: b = f.register_count[7:0];
      POS_CRC_LO:   b = crc[7:0];
      POS_CRC_HI:   b = crc[15:8];
      default:      b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> sv/mbrfb_crc_stage.sv
// One pipeline stage of the frame builder: folds one frame byte into the CRC.
// Depends on mbrfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbrfb_crc_stage
  import mbrfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  stage_t     in_data,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output stage_t     out_data
);

  logic   valid;
  stage_t data;

  // Take a word when empty or when the held word leaves
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Advance the frame and the CRC together
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data.frame <= in_data.frame;
      data.crc   <= crc_byte(in_data.crc, in_byte);
    end
  end

  `MBRFB_ASSERT_NEXT(a_stall_holds, clk, rst, valid && !out_ready,
                     valid && $stable(data.crc))

endmodule

>>> sv/mbrfb_serializer.sv
// Frame serializer: sends a finished frame as eight byte words.
// Depends on mbrfb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module mbrfb_serializer
  import mbrfb_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  stage_t     in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic [2:0] out_pos,
  output logic       out_last
);

  logic       busy;
  logic [2:0] pos;
  stage_t     held;
  logic       out_fire;
  logic       last;

  assign last     = (pos == POS_CRC_HI);
  assign out_fire = busy && out_ready;
  // Load the next frame as the last byte of this one leaves
  assign in_ready = !busy || (out_fire && last);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= POS_ADDR;
    end else if (in_ready) begin
      busy <= in_valid;
      pos  <= POS_ADDR;
    end else if (out_fire) begin
      pos <= pos + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held <= in_data;
    end
  end

  assign out_valid = busy;
  assign out_byte  = frame_byte_at(held.frame, held.crc, pos);
  assign out_pos   = pos;
  assign out_last  = last;

  `MBRFB_ASSERT_NEXT(a_pos_steps, clk, rst, out_fire && !last,
                     busy && (pos == $past(pos) + 3'd1))
  `MBRFB_ASSERT_NEXT(a_frame_restarts, clk, rst, out_fire && last,
                     !busy || (pos == POS_ADDR))
  `MBRFB_ASSERT_NEXT(a_stall_pos, clk, rst, busy && !out_ready,
                     busy && $stable(pos))

endmodule

>>> sv/modbus_request_frame_builder.sv
// Modbus RTU read-request frame builder, top level.
// Depends on mbrfb_pkg, mbrfb_crc_stage and mbrfb_serializer.
//
// Usage:
//   s_* stream: one word per request, start register and register count.
//   m_* stream: eight byte words per request in transmit order: slave
//   address, function code, start register high/low, count high/low,
//   CRC low, CRC high; tlast marks the CRC high byte.
//   cfg_*: write slave address (index 0) and function code (index 1); the user
//   must write them only while the block is idle; the block does not enforce this.
// Path: a request passes the six CRC stages, one byte each, then the serializer
//   register, before the first byte of its frame is valid.
// Flow: the serializer sends one byte per cycle while m_tready is high and takes
//   the next frame as the last byte leaves; up to seven requests are in flight.
// Reset: clears all valid bits, restores slave address 0x93 and function
//   code 0x03.
// Stall: when m_tready is low the current byte holds, the CRC stages fill
//   and then s_tready drops; nothing is lost or repeated.
module modbus_request_frame_builder
  import mbrfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] start_register, [31:16] register_count
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] frame_byte, [10:8] byte_position, [15:11] zero
  output logic        m_tlast,   // last_byte
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data
);

  logic [7:0] slave_address;
  logic [7:0] function_code;

  // Hold the configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      slave_address <= SLAVE_RESET;
      function_code <= FUNC_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SLAVE_ADDRESS: slave_address <= cfg_data;
        CFG_FUNCTION_CODE: function_code <= cfg_data;
        default: ;
      endcase
    end
  end

  logic   st_valid [CRC_BYTES+1];
  logic   st_ready [CRC_BYTES+1];
  stage_t st_data  [CRC_BYTES+1];

  // Build the frame word entering the pipeline
  assign st_valid[0]                    = s_tvalid;
  assign s_tready                       = st_ready[0];
  assign st_data[0].frame.slave_address  = slave_address;
  assign st_data[0].frame.function_code  = function_code;
  assign st_data[0].frame.start_register = s_tdata[15:0];
  assign st_data[0].frame.register_count = s_tdata[31:16];
  assign st_data[0].crc                  = CRC_INIT;

  // Fold one frame byte into the CRC at each stage
  for (genvar k = 0; k < CRC_BYTES; k++) begin : g_crc
    logic [7:0] stage_byte;
    assign stage_byte = frame_byte_at(st_data[k].frame, 16'h0000, 3'(k));

    mbrfb_crc_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (st_valid[k]),
      .in_ready  (st_ready[k]),
      .in_data   (st_data[k]),
      .in_byte   (stage_byte),
      .out_valid (st_valid[k+1]),
      .out_ready (st_ready[k+1]),
      .out_data  (st_data[k+1])
    );
  end

  logic [7:0] out_byte;
  logic [2:0] out_pos;

  mbrfb_serializer u_ser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (st_valid[CRC_BYTES]),
    .in_ready  (st_ready[CRC_BYTES]),
    .in_data   (st_data[CRC_BYTES]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_byte  (out_byte),
    .out_pos   (out_pos),
    .out_last  (m_tlast)
  );

  assign m_tdata = {5'b00000, out_pos, out_byte};

endmodule

>>> verif/mbrfb_frame_checker.sv
`timescale 1ns / 100ps
// Checker for the Modbus request frame builder: watches the request, byte and
// config channels, builds the expected frame bytes and compares them. Uses mbrfb_pkg.
module mbrfb_frame_checker
  import mbrfb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,    // [15:0] start_register, [31:16] register_count
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [15:0] m_tdata,    // [7:0] frame_byte, [10:8] byte_position, [15:11] zero
  input  logic        m_tlast,    // last_byte
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatches,
  output int          bytes_due
);

  typedef struct {
    logic [7:0] data;
    logic [2:0] pos;
    logic       last;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];
  logic [7:0]  slave_address;
  logic [7:0]  function_code;

  // Build one request frame with its CRC and queue its eight bytes
  function automatic void queue_request_frame(input logic [15:0] start_reg,
                                              input logic [15:0] reg_count);
    logic [7:0]  msg [0:7];
    logic [15:0] crc;
    logic        feedback;
    frame_byte_t e;
    msg[0] = slave_address;
    msg[1] = function_code;
    msg[2] = start_reg[15:8];
    msg[3] = start_reg[7:0];
    msg[4] = reg_count[15:8];
    msg[5] = reg_count[7:0];
    // Bit-serial CRC-16, LSB first over the six header bytes
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      for (int k = 0; k < 8; k++) begin
        feedback = crc[0] ^ msg[i][k];
        crc = crc >> 1;
        if (feedback) begin
          crc = crc ^ CRC_POLY;
        end
      end
    end
    msg[6] = crc[7:0];
    msg[7] = crc[15:8];
    for (int i = 0; i < 8; i++) begin
      e.data = msg[i];
      e.pos  = 3'(i);
      e.last = (i == 7);
      expected_bytes.push_back(e);
    end
  endfunction

  always @(posedge clk) begin : monitor
    frame_byte_t e;
    if (rst) begin
      slave_address = SLAVE_RESET;
      function_code = FUNC_RESET;
      mismatches = 0;
      expected_bytes.delete();
    end else begin
      // Predict with the settings in force before this edge
      if (s_tvalid && s_tready) begin
        queue_request_frame(s_tdata[15:0], s_tdata[31:16]);
      end
      // Compare each byte word with the oldest expectation
      if (m_tvalid && m_tready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte word: frame_byte %02h, byte_position %0d, last_byte %0b",
                 m_tdata[7:0], m_tdata[10:8], m_tlast);
          mismatches++;
        end else begin
          e = expected_bytes.pop_front();
          if (m_tdata[7:0] !== e.data) begin
            $error("frame_byte: expected %02h, actual %02h", e.data, m_tdata[7:0]);
            mismatches++;
          end
          if (m_tdata[10:8] !== e.pos) begin
            $error("byte_position: expected %0d, actual %0d", e.pos, m_tdata[10:8]);
            mismatches++;
          end
          if (m_tlast !== e.last) begin
            $error("last_byte: expected %0b, actual %0b", e.last, m_tlast);
            mismatches++;
          end
        end
      end
      // Track register writes
      if (cfg_we) begin
        if (cfg_index == CFG_SLAVE_ADDRESS) begin
          slave_address = cfg_data;
        end else begin
          function_code = cfg_data;
        end
      end
    end
    bytes_due = expected_bytes.size();
  end

endmodule

>>> verif/testbench.sv
`timescale 1ns / 100ps
// Top of the frame builder testbench: clock, reset, request stimulus, config
// writes, byte-side stalls and the verdict. Needs mbrfb_pkg and mbrfb_frame_checker.
module testbench;
  import mbrfb_pkg::*;

  localparam int RESET_CYCLES = 11;
  localparam int QUIET_LIMIT  = 2000;
  localparam int DRAIN_CYCLES = 16;

  typedef enum int {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN,
    READY_LONG_STALLS
  } ready_mode_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_SLAVE_ADDRESS;
  logic [7:0]  cfg_data = '0;

  int          mismatches;
  int          bytes_due;
  ready_mode_t ready_mode = READY_ALWAYS;
  int          gap_max = 0;
  int          burst_max = 1;
  int          burst_left = 0;
  int          stall_left = 0;
  int          cycle_count = 0;
  int          quiet_cycles = 0;

  always #2 clk = ~clk;

  modbus_request_frame_builder u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  mbrfb_frame_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .bytes_due  (bytes_due)
  );

  // Stall the byte side according to the current mode
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    case (ready_mode)
      READY_ALWAYS: begin
        m_tready <= 1'b1;
      end
      READY_RANDOM: begin
        m_tready <= ($urandom_range(0, 3) != 0);
      end
      READY_PATTERN: begin
        m_tready <= ((cycle_count % 13) < 8);
      end
      default: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          m_tready <= 1'b0;
        end else if ($urandom_range(0, 24) == 0) begin
          stall_left <= $urandom_range(4, 40);
          m_tready <= 1'b0;
        end else begin
          m_tready <= 1'b1;
        end
      end
    endcase
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request word, opening a gap first when a burst has run out
  task automatic send_request(input logic [15:0] start_reg, input logic [15:0] reg_count);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, burst_max);
      if (gap_max > 0) begin
        gap = $urandom_range(0, gap_max);
        if (gap > 0) begin
          s_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= {reg_count, start_reg};
    do @(posedge clk); while (!s_tready);
  endtask

  // Hold off requests until every expected byte has come out
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (bytes_due != 0);
  endtask

  task automatic write_config(input logic [7:0] slave, input logic [7:0] func);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_SLAVE_ADDRESS;
    cfg_data  <= slave;
    @(posedge clk);
    cfg_index <= CFG_FUNCTION_CODE;
    cfg_data  <= func;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic send_random_request();
    logic [15:0] start_reg;
    logic [15:0] reg_count;
    case ($urandom_range(0, 9))
      0: begin
        start_reg = 16'($urandom_range(0, 15));
        reg_count = 16'($urandom_range(1, 125));
      end
      1: begin
        start_reg = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
        reg_count = 16'($urandom);
      end
      2: begin
        start_reg = 16'($urandom);
        reg_count = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      end
      default: begin
        start_reg = 16'($urandom);
        reg_count = 16'($urandom);
      end
    endcase
    send_request(start_reg, reg_count);
  endtask

  // One random phase under fresh settings; pause for a full drain midway
  task automatic run_random_phase(input int n_items, input ready_mode_t mode,
                                  input int gmax, input int bmax);
    write_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
    ready_mode = mode;
    gap_max    = gmax;
    burst_max  = bmax;
    for (int i = 0; i < n_items; i++) begin
      if (i == n_items / 2) begin
        wait_idle();
      end
      send_random_request();
    end
    wait_idle();
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Field extremes under the reset address and function code
    send_request(16'h0000, 16'h0000);
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'h0000, 16'hFFFF);
    send_request(16'hFFFF, 16'h0000);
    send_request(16'h0001, 16'h0001);
    send_request(16'h8000, 16'h8000);
    send_request(16'h7FFF, 16'h7FFF);
    send_request(16'h006B, 16'h0003);
    wait_idle();

    // All-zero address and function code
    write_config(8'h00, 8'h00);
    send_request(16'h0000, 16'h0000);
    send_request(16'hA55A, 16'h5AA5);
    send_request(16'hFFFF, 16'h0001);
    wait_idle();

    // All-ones address and function code, with byte-side stalls
    write_config(8'hFF, 8'hFF);
    ready_mode = READY_PATTERN;
    send_request(16'hFFFF, 16'hFFFF);
    send_request(16'h1234, 16'h0000);
    send_request(16'h0000, 16'h007D);
    wait_idle();

    run_random_phase(55, READY_RANDOM, 6, 8);
    run_random_phase(50, READY_ALWAYS, 0, 1);
    run_random_phase(55, READY_PATTERN, 12, 4);
    run_random_phase(50, READY_LONG_STALLS, 20, 10);

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

>>> modbus_request_frame_builder.f
+incdir+sv
sv/mbrfb_pkg.sv
sv/mbrfb_crc_stage.sv
sv/mbrfb_serializer.sv
sv/modbus_request_frame_builder.sv
verif/mbrfb_frame_checker.sv
verif/testbench.sv
